// ----- rtl/hcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared constants and the classified byte record of the chunked decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

  localparam int COUNT_BITS  = 32;
  localparam int RADIX       = 16;
  localparam int DIGIT_BITS  = $clog2(RADIX);
  localparam int LENGTH_BITS = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef struct packed {
    logic [7:0]            data;
    logic                  last;
    logic                  is_lf;
    logic                  is_cr;
    logic                  is_blank;
    logic                  is_hex;
    logic [DIGIT_BITS-1:0] digit;
  } hcd_item_t;

endpackage

// ----- rtl/hcd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_front
// Accepts input transactions and tags each byte with its character class.
// ----------------------------------------------------------------------------
module hcd_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] in_byte
  input  logic              s_tlast,   // in_last
  input  logic              queue_full,
  output logic              push,
  output hcd_pkg::hcd_item_t item
);

  logic [7:0] c;

  assign c        = s_tdata;
  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  always_comb begin
    item          = '0;
    item.data     = c;
    item.last     = s_tlast;
    item.is_lf    = (c == hcd_pkg::CH_LF);
    item.is_cr    = (c == hcd_pkg::CH_CR);
    item.is_blank = (c inside {hcd_pkg::CH_SP, hcd_pkg::CH_HT, hcd_pkg::CH_VT,
                               hcd_pkg::CH_FF, hcd_pkg::CH_CR});
    if (c inside {[8'h30:8'h39]}) begin
      item.is_hex = 1'b1;
      item.digit  = hcd_pkg::DIGIT_BITS'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      item.is_hex = 1'b1;
      item.digit  = hcd_pkg::DIGIT_BITS'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      item.is_hex = 1'b1;
      item.digit  = hcd_pkg::DIGIT_BITS'(c - 8'h57);
    end
  end

endmodule

// ----- rtl/hcd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_queue
// Short queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module hcd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hcd_pkg::hcd_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output hcd_pkg::hcd_item_t head_item
);

  hcd_pkg::hcd_item_t              mem [hcd_pkg::QUEUE_DEPTH];
  logic [hcd_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [hcd_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [hcd_pkg::QCNT_BITS-1:0]   count;
  logic                            do_pop;

  localparam logic [hcd_pkg::QPTR_BITS-1:0] LAST_PTR =
    hcd_pkg::QPTR_BITS'(hcd_pkg::QUEUE_DEPTH - 1);

  assign full       = (count == hcd_pkg::QCNT_BITS'(hcd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/hcd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_back
// Chunk parser: runs the size-line / data state machine on each queued byte
// and registers the result transaction.
// ----------------------------------------------------------------------------
module hcd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  hcd_pkg::hcd_item_t item,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [39:0]        m_tdata,   // [7:0] out_byte, [39:8] body_length
  output logic               m_tlast,   // done_res
  output logic [1:0]         m_tuser    // [0] byte_valid, [1] error
);

  typedef enum logic [2:0] {
    PH_SKIP, PH_DIGITS, PH_EXT, PH_DATA, PH_AFTER_CR, PH_AFTER_LF, PH_DONE, PH_FAILED
  } phase_t;

  localparam int CB = hcd_pkg::COUNT_BITS;
  localparam int DB = hcd_pkg::DIGIT_BITS;

  phase_t                          phase, phase_next, ph;
  logic [CB-1:0]                   remaining, remaining_next, remaining_dec;
  logic [hcd_pkg::LENGTH_BITS-1:0] total, total_next;
  logic                            ovf, ovf_next;
  logic                            consumed, line_end, hit_valid, trunc;
  logic                            result, err;

  assign pop           = head_valid && (!m_tvalid || m_tready);
  assign remaining_dec = remaining - 1'b1;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    total_next     = total;
    ovf_next       = ovf;
    ph             = phase;
    consumed       = 1'b0;
    line_end       = 1'b0;
    hit_valid      = 1'b0;
    trunc          = 1'b0;

    // optional CR then optional LF after chunk data
    if (ph == PH_AFTER_CR) begin
      if (item.is_cr) begin
        phase_next = PH_AFTER_LF;
        consumed   = 1'b1;
      end else begin
        ph = PH_AFTER_LF;
      end
    end
    if (!consumed && ph == PH_AFTER_LF) begin
      ph         = PH_SKIP;
      phase_next = PH_SKIP;
      consumed   = item.is_lf;
    end

    if (!consumed) begin
      case (ph)
        PH_SKIP, PH_DIGITS: begin
          if (item.is_lf) begin
            line_end = 1'b1;
          end else if (!(ph == PH_SKIP && item.is_blank)) begin
            if (!item.is_hex) begin
              phase_next = PH_EXT;
            end else begin
              phase_next = PH_DIGITS;
              if (remaining[CB-1 -: DB] != '0) begin
                ovf_next = 1'b1;
              end else begin
                remaining_next = {remaining[CB-DB-1:0], item.digit};
              end
            end
          end
        end
        PH_EXT: begin
          line_end = item.is_lf;
        end
        PH_DATA: begin
          hit_valid      = 1'b1;
          remaining_next = remaining_dec;
          if (total != '1) begin
            total_next = total + 1'b1;
          end
          if (remaining_dec == '0) begin
            phase_next = PH_AFTER_CR;
          end else begin
            trunc = 1'b1;
          end
        end
        default: ;
      endcase

      if (line_end) begin
        if (ovf) begin
          phase_next = PH_FAILED;
        end else if (remaining == '0) begin
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_DATA;
          trunc      = 1'b1;
        end
      end
    end

    result = hit_valid || item.last;
    err    = item.last && (trunc || phase_next == PH_FAILED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SKIP;
      remaining <= '0;
      total     <= '0;
      ovf       <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (pop) begin
        if (item.last) begin
          phase     <= PH_SKIP;
          remaining <= '0;
          total     <= '0;
          ovf       <= 1'b0;
        end else begin
          phase     <= phase_next;
          remaining <= remaining_next;
          total     <= total_next;
          ovf       <= ovf_next;
        end
      end
      if (pop && result) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {total_next, hit_valid ? item.data : 8'h00};
        m_tlast  <= item.last;
        m_tuser  <= {err, hit_valid};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_err_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("error flagged on a transaction that is not the last");

  a_empty_is_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tlast && m_tdata[7:0] == 8'h00))
    else $error("result without data byte is not a clean end transaction");

  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    pop && item.last |=> (phase == PH_SKIP && total == '0 && !ovf && remaining == '0))
    else $error("parser state not cleared after the last byte");

  a_data_has_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> remaining != '0)
    else $error("in chunk data with no bytes left");

endmodule

// ----- rtl/http_chunked_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_decoder_unit
// Chunked transfer decoder: strips size lines and passes on chunk data.
//
// Input stream s_*: one encoded body byte per transaction, s_tlast on the
// final byte of the body. Output stream m_*: one transaction per chunk data
// byte (m_tuser[0] set) plus one for the final input byte (m_tlast set);
// m_tuser[1] on that final transaction flags a truncated chunk or an
// oversize count, and m_tdata[39:8] carries the running decoded length.
// Bytes that are framing only produce no output transaction.
//
// Throughput is one byte per clock while m_tready is high: the parser back end
// updates its state on each byte it pops. The byte is written to the queue at
// the accepting edge, and the parser loads the output register from the queue
// head when it pops that byte.
// A four-entry queue sits between classifier and parser; when m_tready is
// low the output register holds, the queue fills, and s_tready drops only
// once it is full. Reset (rst, synchronous) empties the queue and returns
// the parser to the start of a size line; after each s_tlast byte the parser
// also returns there, ready for the next body.
// ----------------------------------------------------------------------------
module http_chunked_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] out_byte, [39:8] body_length
  output logic        m_tlast,   // done_res
  output logic [1:0]  m_tuser    // [0] byte_valid, [1] error
);

  hcd_pkg::hcd_item_t push_item;
  hcd_pkg::hcd_item_t head_item;
  logic               push, full, pop, head_valid;

  hcd_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .queue_full (full),
    .push       (push),
    .item       (push_item)
  );

  hcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  hcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .item       (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
